// ===== design/hrf_pkg.sv =====
// Shared types, constants and a helper function of the HTTP request framer.
package hrf_pkg;

   // Field widths
   localparam int DATA_W  = 8;
   localparam int LEN_W   = 24;
   localparam int COUNT_W = 32;
   localparam int POS_W   = 5;

   // Characters that the parser looks for
   localparam logic [DATA_W-1:0] CHAR_LF      = 8'h0A;
   localparam logic [DATA_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [DATA_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [DATA_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [DATA_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [DATA_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [DATA_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [DATA_W-1:0] CHAR_VT      = 8'h0B;
   localparam logic [DATA_W-1:0] CHAR_FF      = 8'h0C;
   localparam logic [DATA_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [DATA_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [DATA_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [DATA_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [DATA_W-1:0] CASE_OFFSET  = 8'h20;

   // Positions of the header name matcher
   localparam logic [POS_W-1:0] POS_FIRST   = 5'd0;
   localparam logic [POS_W-1:0] NAME_LEN    = 5'd14;
   localparam logic [POS_W-1:0] POS_COLON   = 5'd14;
   localparam logic [POS_W-1:0] POS_SKIP    = 5'd15;
   localparam logic [POS_W-1:0] POS_DIG_POS = 5'd16;
   localparam logic [POS_W-1:0] POS_DIG_NEG = 5'd17;
   localparam logic [POS_W-1:0] POS_IDLE    = 5'd31;

   localparam logic [LEN_W-1:0] LIMIT_RESET = 24'hFFFFFF;

   // Partial header terminator seen so far
   typedef enum logic [2:0] {
      TRK_NONE,
      TRK_CR,
      TRK_CRLF,
      TRK_CRLFCR,
      TRK_LF
   } trk_type;

   typedef enum logic {
      PHASE_HEADERS,
      PHASE_BODY
   } phase_type;

   // One request beat
   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              new_request;
      logic              end_of_stream;
   } req_item_type;

   // One response beat
   typedef struct packed {
      logic               headers_done;
      logic               request_complete;
      logic [LEN_W-1:0]   body_length;
      logic [COUNT_W-1:0] header_length;
      logic [COUNT_W-1:0] byte_count;
   } rsp_item_type;

   // Lower-case spelling of the Content-Length header name, one letter per position.
   function automatic logic [DATA_W-1:0] name_char(input logic [3:0] idx);
      logic [DATA_W-1:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h6C; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/hrf_if.sv =====
// Valid/ready channel interfaces for request and response beats.
interface hrf_req_if;
   logic                      valid;
   logic                      ready;
   logic [hrf_pkg::DATA_W-1:0] data_byte;
   logic                      new_request;
   logic                      end_of_stream;

   modport source (output valid, output data_byte, output new_request,
                   output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input new_request,
                   input end_of_stream, output ready);
endinterface

interface hrf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        headers_done;
   logic                        request_complete;
   logic [hrf_pkg::LEN_W-1:0]   body_length;
   logic [hrf_pkg::COUNT_W-1:0] header_length;
   logic [hrf_pkg::COUNT_W-1:0] byte_count;

   modport source (output valid, output headers_done, output request_complete,
                   output body_length, output header_length,
                   output byte_count, input ready);
   modport sink   (input valid, input headers_done, input request_complete,
                   input body_length, input header_length,
                   input byte_count, output ready);
endinterface

// ===== design/hrf_parser.sv =====
// Parse state of the framer and its update for one request beat.
module hrf_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  hrf_pkg::req_item_type         item,
   input  logic [hrf_pkg::LEN_W-1:0]     length_limit,
   output hrf_pkg::rsp_item_type         result
);

   hrf_pkg::phase_type            phase_ff, phase_in, phase_c;
   hrf_pkg::trk_type              trk_ff, trk_in, trk_c;
   logic                          line_start_ff, line_start_in, line_start_c;
   logic [hrf_pkg::POS_W-1:0]     pos_ff, pos_in, pos_c, pos_start;
   logic                          found_ff, found_in, found_c;
   logic [hrf_pkg::LEN_W-1:0]     len_ff, len_in, len_c;
   logic [hrf_pkg::COUNT_W-1:0]   hdr_ff, hdr_in, hdr_c;
   logic [hrf_pkg::COUNT_W-1:0]   rcv_ff, rcv_in, rcv_c;
   logic                          done_ff, done_in, done_c;

   logic [hrf_pkg::DATA_W-1:0]    b, lc;
   logic                          is_digit, is_space;
   logic [3:0]                    dval;
   logic [hrf_pkg::LEN_W+3:0]     acc;
   logic [hrf_pkg::LEN_W-1:0]     acc_clamped;
   logic [hrf_pkg::COUNT_W:0]     need;

   // A new request starts from the cleared state before its byte is taken
   always_comb begin
      if (item.new_request) begin
         phase_c      = hrf_pkg::PHASE_HEADERS;
         trk_c        = hrf_pkg::TRK_NONE;
         line_start_c = 1'b1;
         pos_c        = hrf_pkg::POS_FIRST;
         found_c      = 1'b0;
         len_c        = '0;
         hdr_c        = '0;
         rcv_c        = '0;
         done_c       = 1'b0;
      end else begin
         phase_c      = phase_ff;
         trk_c        = trk_ff;
         line_start_c = line_start_ff;
         pos_c        = pos_ff;
         found_c      = found_ff;
         len_c        = len_ff;
         hdr_c        = hdr_ff;
         rcv_c        = rcv_ff;
         done_c       = done_ff;
      end
   end

   // Byte classification and the decimal accumulator
   always_comb begin
      b        = item.data_byte;
      lc       = (b >= hrf_pkg::CHAR_UPPER_A && b <= hrf_pkg::CHAR_UPPER_Z) ?
                 b + hrf_pkg::CASE_OFFSET : b;
      is_digit = (b >= hrf_pkg::CHAR_ZERO) && (b <= hrf_pkg::CHAR_NINE);
      is_space = (b == hrf_pkg::CHAR_SPACE) || (b == hrf_pkg::CHAR_TAB) ||
                 (b == hrf_pkg::CHAR_VT) || (b == hrf_pkg::CHAR_FF);
      dval     = b[3:0];
      // value * 10 + digit, as two shifted copies and the digit
      acc      = {1'b0, len_c, 3'b000} + {3'b000, len_c, 1'b0} +
                 {{hrf_pkg::LEN_W{1'b0}}, dval};
      acc_clamped = (acc > {4'b0000, length_limit}) ? length_limit :
                    acc[hrf_pkg::LEN_W-1:0];
      // Total byte count needed once the headers are known
      need     = {1'b0, hdr_c} + {{(hrf_pkg::COUNT_W-hrf_pkg::LEN_W+1){1'b0}}, len_c};
   end

   // Next state for the beat
   always_comb begin
      phase_in      = phase_c;
      trk_in        = trk_c;
      line_start_in = line_start_c;
      pos_in        = pos_c;
      found_in      = found_c;
      len_in        = len_c;
      hdr_in        = hdr_c;
      rcv_in        = rcv_c;
      done_in       = done_c;
      pos_start     = line_start_c ? (found_c ? hrf_pkg::POS_IDLE : hrf_pkg::POS_FIRST)
                                   : pos_c;

      if (!done_c) begin
         if (item.end_of_stream) begin
            done_in = 1'b1;
         end else begin
            if (rcv_c != '1) begin
               rcv_in = rcv_c + 1'b1;
            end
            if (phase_c == hrf_pkg::PHASE_HEADERS) begin
               // Header name, colon and value matcher
               priority if (pos_start < hrf_pkg::NAME_LEN) begin
                  pos_in = (lc == hrf_pkg::name_char(pos_start[3:0])) ?
                           pos_start + 1'b1 : hrf_pkg::POS_IDLE;
               end else if (pos_start == hrf_pkg::POS_COLON) begin
                  if (b == hrf_pkg::CHAR_COLON) begin
                     pos_in   = hrf_pkg::POS_SKIP;
                     found_in = 1'b1;
                  end else begin
                     pos_in = hrf_pkg::POS_IDLE;
                  end
               end else if (pos_start == hrf_pkg::POS_SKIP) begin
                  priority if (is_space) begin
                     pos_in = hrf_pkg::POS_SKIP;
                  end else if (b == hrf_pkg::CHAR_PLUS) begin
                     pos_in = hrf_pkg::POS_DIG_POS;
                  end else if (b == hrf_pkg::CHAR_MINUS) begin
                     pos_in = hrf_pkg::POS_DIG_NEG;
                  end else if (is_digit) begin
                     len_in = acc_clamped;
                     pos_in = hrf_pkg::POS_DIG_POS;
                  end else begin
                     pos_in = hrf_pkg::POS_IDLE;
                  end
               end else if (pos_start == hrf_pkg::POS_DIG_POS) begin
                  if (is_digit) begin
                     len_in = acc_clamped;
                     pos_in = pos_start;
                  end else begin
                     pos_in = hrf_pkg::POS_IDLE;
                  end
               end else if (pos_start == hrf_pkg::POS_DIG_NEG) begin
                  // Any nonzero digit of a negative value saturates
                  if (is_digit) begin
                     if (dval != 4'd0) begin
                        len_in = length_limit;
                     end
                     pos_in = pos_start;
                  end else begin
                     pos_in = hrf_pkg::POS_IDLE;
                  end
               end else begin
                  pos_in = hrf_pkg::POS_IDLE;
               end

               // A line starts after CR LF only
               line_start_in = (b == hrf_pkg::CHAR_LF) &&
                               (trk_c == hrf_pkg::TRK_CR || trk_c == hrf_pkg::TRK_CRLFCR);

               // Terminator tracking; LF never changes the length value
               if (b == hrf_pkg::CHAR_LF) begin
                  if (trk_c == hrf_pkg::TRK_CRLFCR || trk_c == hrf_pkg::TRK_CRLF ||
                      trk_c == hrf_pkg::TRK_LF) begin
                     trk_in   = hrf_pkg::TRK_NONE;
                     phase_in = hrf_pkg::PHASE_BODY;
                     hdr_in   = rcv_in;
                     if (len_c == '0) begin
                        done_in = 1'b1;
                     end
                  end else if (trk_c == hrf_pkg::TRK_CR) begin
                     trk_in = hrf_pkg::TRK_CRLF;
                  end else begin
                     trk_in = hrf_pkg::TRK_LF;
                  end
               end else if (b == hrf_pkg::CHAR_CR) begin
                  trk_in = (trk_c == hrf_pkg::TRK_CRLF) ? hrf_pkg::TRK_CRLFCR
                                                        : hrf_pkg::TRK_CR;
               end else begin
                  trk_in = hrf_pkg::TRK_NONE;
               end
            end else begin
               // Body bytes are only counted and checked against the total byte count needed
               if ({1'b0, rcv_in} >= need) begin
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   // State registers, updated once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hrf_pkg::PHASE_HEADERS;
         trk_ff        <= hrf_pkg::TRK_NONE;
         line_start_ff <= 1'b1;
         pos_ff        <= hrf_pkg::POS_FIRST;
         found_ff      <= 1'b0;
         len_ff        <= '0;
         hdr_ff        <= '0;
         rcv_ff        <= '0;
         done_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         trk_ff        <= trk_in;
         line_start_ff <= line_start_in;
         pos_ff        <= pos_in;
         found_ff      <= found_in;
         len_ff        <= len_in;
         hdr_ff        <= hdr_in;
         rcv_ff        <= rcv_in;
         done_ff       <= done_in;
      end
   end

   // Result of the beat is the state it leaves behind
   always_comb begin
      result.headers_done     = (phase_in == hrf_pkg::PHASE_BODY);
      result.request_complete = done_in;
      result.body_length      = len_in;
      result.header_length    = hdr_in;
      result.byte_count       = rcv_in;
   end

   // The terminator tracker is idle throughout the body.
   a_body_trk_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hrf_pkg::PHASE_BODY) |-> (trk_ff == hrf_pkg::TRK_NONE))
      else $error("terminator tracker active after headers");

   // A header length is recorded exactly when the headers are done.
   a_hdr_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == hrf_pkg::PHASE_BODY) == (hdr_ff != '0))
      else $error("header length out of step with phase");

   // A nonzero length can only come after a matched header name and colon.
   a_len_found: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> found_ff)
      else $error("content length without header");

   // A completed request stops counting until the next request starts.
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (step && done_ff && !item.new_request) |=> ($stable(rcv_ff) && done_ff))
      else $error("completed request changed");

endmodule

// ===== design/http_request_framer.sv =====
// Top level of the HTTP request framer: beat registers, limit register and parser.
//
// The framer takes one request byte per beat and returns one response beat for
// each, at a sustained rate of one beat per clock cycle while the response side
// does not stall. A beat is captured in an input register; the parser then
// updates its state from it while the response is loaded into an output
// register, which offers it on rsp_bus. When the response side stalls, the
// input register holds one further beat before req_bus.ready falls. No clearing
// pass is needed after reset. csr_write_data sets the Content-Length ceiling
// and should be written only while no beat is in flight.
module http_request_framer (
   input  logic                      clock,
   input  logic                      reset,
   hrf_req_if.sink                   req_bus,
   hrf_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [hrf_pkg::LEN_W-1:0] csr_write_data
);

   logic                      in_valid_ff, in_valid_in;
   hrf_pkg::req_item_type     in_item_ff, in_item_in;
   logic                      out_valid_ff, out_valid_in;
   hrf_pkg::rsp_item_type     out_item_ff, out_item_in;
   logic [hrf_pkg::LEN_W-1:0] limit_ff, limit_in;
   hrf_pkg::rsp_item_type     result;
   logic                      advance, step;

   // Pipeline flow control
   always_comb begin
      advance       = !out_valid_ff || rsp_bus.ready;
      step          = in_valid_ff && advance;
      req_bus.ready = !in_valid_ff || advance;
      in_valid_in   = req_bus.ready ? req_bus.valid : in_valid_ff;
      in_item_in    = in_item_ff;
      if (req_bus.ready && req_bus.valid) begin
         in_item_in.data_byte     = req_bus.data_byte;
         in_item_in.new_request   = req_bus.new_request;
         in_item_in.end_of_stream = req_bus.end_of_stream;
      end
      out_valid_in  = advance ? in_valid_ff : out_valid_ff;
      out_item_in   = step ? result : out_item_ff;
      limit_in      = csr_write_enable ? csr_write_data : limit_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= hrf_pkg::LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         limit_ff     <= limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   hrf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (in_item_ff),
      .length_limit (limit_ff),
      .result       (result)
   );

   // Response beat
   always_comb begin
      rsp_bus.valid            = out_valid_ff;
      rsp_bus.headers_done     = out_item_ff.headers_done;
      rsp_bus.request_complete = out_item_ff.request_complete;
      rsp_bus.body_length      = out_item_ff.body_length;
      rsp_bus.header_length    = out_item_ff.header_length;
      rsp_bus.byte_count       = out_item_ff.byte_count;
   end

endmodule

// ===== bench/hrf_response_checker.sv =====
// Checker for the HTTP request framer: predicts each response beat and compares it.
module hrf_response_checker (
   input  logic                      clock,
   input  logic                      reset,
   hrf_req_if                        req_mon,
   hrf_rsp_if                        rsp_mon,
   input  logic                      csr_write_enable,
   input  logic [hrf_pkg::LEN_W-1:0] csr_write_data,
   output int                        pending_results,
   output int                        failures
);

   // Header name as the parser compares it, after folding to lower case.
   localparam logic [8*14-1:0] FIELD_NAME = "content-length";

   // Predicted parser state and the length ceiling.
   logic [hrf_pkg::LEN_W-1:0]   length_limit;
   hrf_pkg::phase_type          parse_phase;
   hrf_pkg::trk_type            term_track;
   logic                        at_line_start;
   logic [hrf_pkg::POS_W-1:0]   match_pos;
   logic                        length_seen;
   logic [hrf_pkg::LEN_W-1:0]   length_val;
   logic [hrf_pkg::COUNT_W-1:0] header_total;
   logic [hrf_pkg::COUNT_W-1:0] received;
   logic                        complete;

   hrf_pkg::rsp_item_type expected_rsp[$];
   int fail_count = 0;
   int pending_count = 0;

   assign failures        = fail_count;
   assign pending_results = pending_count;

   task automatic clear_request();
      parse_phase   = hrf_pkg::PHASE_HEADERS;
      term_track    = hrf_pkg::TRK_NONE;
      at_line_start = 1'b1;
      match_pos     = hrf_pkg::POS_FIRST;
      length_seen   = 1'b0;
      length_val    = '0;
      header_total  = '0;
      received      = '0;
      complete      = 1'b0;
   endtask

   // A minus sign followed by any nonzero digit saturates; otherwise the value is clamped.
   task automatic take_length_digit(input logic [hrf_pkg::DATA_W-1:0] b,
                                    input logic negative);
      logic [63:0]                grown;
      logic [hrf_pkg::DATA_W-1:0] digit;
      digit = b - hrf_pkg::CHAR_ZERO;
      if (negative) begin
         if (digit != '0) length_val = length_limit;
      end else begin
         grown = 64'(length_val) * 64'd10 + 64'(digit);
         if (grown > 64'(length_limit)) grown = 64'(length_limit);
         length_val = grown[hrf_pkg::LEN_W-1:0];
      end
   endtask

   // Content-Length name, colon, blanks, optional sign and digits.
   task automatic match_header_byte(input logic [hrf_pkg::DATA_W-1:0] b);
      logic [hrf_pkg::POS_W-1:0]  pos;
      logic [hrf_pkg::DATA_W-1:0] folded;
      logic                       is_digit;
      pos = match_pos;
      is_digit = (b >= hrf_pkg::CHAR_ZERO) && (b <= hrf_pkg::CHAR_NINE);
      if (at_line_start) pos = length_seen ? hrf_pkg::POS_IDLE : hrf_pkg::POS_FIRST;
      if (pos < hrf_pkg::NAME_LEN) begin
         folded = (b >= hrf_pkg::CHAR_UPPER_A && b <= hrf_pkg::CHAR_UPPER_Z) ?
                  b + hrf_pkg::CASE_OFFSET : b;
         pos = (folded == FIELD_NAME[8*(13 - int'(pos)) +: 8]) ? pos + 1'b1
                                                               : hrf_pkg::POS_IDLE;
      end else if (pos == hrf_pkg::POS_COLON) begin
         if (b == hrf_pkg::CHAR_COLON) begin
            pos = hrf_pkg::POS_SKIP;
            length_seen = 1'b1;
         end else begin
            pos = hrf_pkg::POS_IDLE;
         end
      end else if (pos == hrf_pkg::POS_SKIP) begin
         if (b == hrf_pkg::CHAR_SPACE || b == hrf_pkg::CHAR_TAB ||
             b == hrf_pkg::CHAR_VT || b == hrf_pkg::CHAR_FF) begin
            pos = hrf_pkg::POS_SKIP;
         end else if (b == hrf_pkg::CHAR_PLUS) begin
            pos = hrf_pkg::POS_DIG_POS;
         end else if (b == hrf_pkg::CHAR_MINUS) begin
            pos = hrf_pkg::POS_DIG_NEG;
         end else if (is_digit) begin
            take_length_digit(b, 1'b0);
            pos = hrf_pkg::POS_DIG_POS;
         end else begin
            pos = hrf_pkg::POS_IDLE;
         end
      end else if (pos == hrf_pkg::POS_DIG_POS || pos == hrf_pkg::POS_DIG_NEG) begin
         if (is_digit) take_length_digit(b, pos == hrf_pkg::POS_DIG_NEG);
         else pos = hrf_pkg::POS_IDLE;
      end else begin
         pos = hrf_pkg::POS_IDLE;
      end
      match_pos = pos;
   endtask

   // Count the byte and, while headers arrive, parse it and track the terminator.
   task automatic take_request_byte(input logic [hrf_pkg::DATA_W-1:0] b);
      hrf_pkg::trk_type prev;
      logic             found;
      found = 1'b0;
      if (received != '1) received = received + 1'b1;
      if (parse_phase == hrf_pkg::PHASE_HEADERS) begin
         prev = term_track;
         match_header_byte(b);
         at_line_start = (b == hrf_pkg::CHAR_LF) &&
                         (prev == hrf_pkg::TRK_CR || prev == hrf_pkg::TRK_CRLFCR);
         if (b == hrf_pkg::CHAR_LF) begin
            if (prev == hrf_pkg::TRK_CRLFCR || prev == hrf_pkg::TRK_CRLF ||
                prev == hrf_pkg::TRK_LF) found = 1'b1;
            else if (prev == hrf_pkg::TRK_CR) term_track = hrf_pkg::TRK_CRLF;
            else term_track = hrf_pkg::TRK_LF;
         end else if (b == hrf_pkg::CHAR_CR) begin
            term_track = (prev == hrf_pkg::TRK_CRLF) ? hrf_pkg::TRK_CRLFCR : hrf_pkg::TRK_CR;
         end else begin
            term_track = hrf_pkg::TRK_NONE;
         end
         if (found) begin
            term_track   = hrf_pkg::TRK_NONE;
            parse_phase  = hrf_pkg::PHASE_BODY;
            header_total = received;
         end
      end
   endtask

   // Work out the response beat that one request beat causes.
   task automatic predict_response(input logic [hrf_pkg::DATA_W-1:0] b, input logic starts,
                                   input logic closed);
      hrf_pkg::rsp_item_type beat;
      if (starts) clear_request();
      if (!complete) begin
         if (closed) begin
            complete = 1'b1;
         end else begin
            take_request_byte(b);
            if (parse_phase == hrf_pkg::PHASE_BODY &&
                33'(received) >= 33'(header_total) + 33'(length_val)) complete = 1'b1;
         end
      end
      beat.headers_done     = (parse_phase == hrf_pkg::PHASE_BODY);
      beat.request_complete = complete;
      beat.body_length      = length_val;
      beat.header_length    = header_total;
      beat.byte_count       = received;
      expected_rsp.push_back(beat);
   endtask

   task automatic check_field(input string field, input logic [hrf_pkg::COUNT_W-1:0] want,
                              input logic [hrf_pkg::COUNT_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Responses are checked before the request beat of the same edge is predicted.
   always @(posedge clock) begin
      hrf_pkg::rsp_item_type want;
      if (reset) begin
         length_limit = hrf_pkg::LIMIT_RESET;
         clear_request();
         expected_rsp.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: response beat with none expected, byte_count %0h", $time,
                        rsp_mon.byte_count);
            end else begin
               want = expected_rsp.pop_front();
               check_field("headers_done", 32'(want.headers_done), 32'(rsp_mon.headers_done));
               check_field("request_complete", 32'(want.request_complete),
                           32'(rsp_mon.request_complete));
               check_field("body_length", 32'(want.body_length),
                           32'(rsp_mon.body_length));
               check_field("header_length", want.header_length, rsp_mon.header_length);
               check_field("byte_count", want.byte_count, rsp_mon.byte_count);
            end
         end
         if (csr_write_enable) length_limit = csr_write_data;
         if (req_mon.valid && req_mon.ready) begin
            predict_response(req_mon.data_byte, req_mon.new_request, req_mon.end_of_stream);
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

// ===== bench/http_request_framer_tb.sv =====
// Testbench top for the HTTP request framer: stimulus, receiver stalls and verdict.
module http_request_framer_tb;

   localparam int DATA_W         = hrf_pkg::DATA_W;
   localparam int LEN_W          = hrf_pkg::LEN_W;
   localparam int PHASE_ITEMS    = 120;
   localparam int LONG_HOLD      = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;
   int               pending_results;
   int               failures;

   hrf_req_if req_bus ();
   hrf_rsp_if rsp_bus ();

   // Beats of the requests still to be sent.
   hrf_pkg::req_item_type beat_plan[$];
   int                    items_planned;
   int                    burst_left = 0;
   int                    quiet_cycles = 0;
   bit                    long_hold_request = 1'b0;
   bit                    crlf_style;

   http_request_framer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   hrf_response_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .pending_results  (pending_results),
      .failures         (failures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Ends the run when no beat has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stretches of free running and of random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      int mode_left;
      bit free_run;
      hold_left = 0;
      mode_left = 0;
      free_run = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               free_run = ($urandom_range(0, 2) == 0);
               mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            rsp_bus.ready <= free_run || ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic push_beat(input logic [DATA_W-1:0] b, input logic starts,
                            input logic closed);
      hrf_pkg::req_item_type beat;
      beat.data_byte     = b;
      beat.new_request   = starts;
      beat.end_of_stream = closed;
      beat_plan.push_back(beat);
   endtask

   task automatic push_byte(input logic [DATA_W-1:0] b);
      push_beat(b, 1'b0, 1'b0);
   endtask

   // The byte of an end-of-stream beat is ignored, so it is random.
   task automatic push_eos();
      push_beat(DATA_W'($urandom), 1'b0, 1'b1);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_eol();
      if (crlf_style) push_byte(hrf_pkg::CHAR_CR);
      push_byte(hrf_pkg::CHAR_LF);
   endtask

   function automatic logic [DATA_W-1:0] blank_byte();
      case ($urandom_range(0, 3))
         0:       return hrf_pkg::CHAR_SPACE;
         1:       return hrf_pkg::CHAR_TAB;
         2:       return hrf_pkg::CHAR_VT;
         default: return hrf_pkg::CHAR_FF;
      endcase
   endfunction

   // Noise leans towards the bytes that the parser reacts to.
   function automatic logic [DATA_W-1:0] noise_byte();
      case ($urandom_range(0, 4))
         0:       return hrf_pkg::CHAR_CR;
         1:       return hrf_pkg::CHAR_LF;
         2:       return hrf_pkg::CHAR_COLON;
         3:       return DATA_W'(hrf_pkg::CHAR_ZERO + $urandom_range(0, 9));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // One Content-Length line with random letter case, blanks, sign and digits;
   // now and then the name or the colon is spoilt.
   task automatic plan_length_line(output int value, output bit open_ended);
      string             name;
      logic [DATA_W-1:0] ch;
      int                spoil_at;
      int                sign;
      name = "content-length";
      value = 0;
      open_ended = 1'b0;
      spoil_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 13) : -1;
      for (int i = 0; i < 14; i++) begin
         ch = name[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - hrf_pkg::CASE_OFFSET;
         push_byte((i == spoil_at) ? "x" : ch);
      end
      push_byte(($urandom_range(0, 11) == 0) ? hrf_pkg::CHAR_SPACE : hrf_pkg::CHAR_COLON);
      repeat ($urandom_range(0, 2)) push_byte(blank_byte());
      sign = $urandom_range(0, 9);
      if (sign == 0) begin
         push_byte(hrf_pkg::CHAR_PLUS);
      end else if (sign == 1) begin
         push_byte(hrf_pkg::CHAR_MINUS);
         open_ended = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
         // Far beyond any body that will be sent, so the stream is closed instead.
         open_ended = 1'b1;
         repeat (8) push_byte(DATA_W'(hrf_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end else begin
         value = $urandom_range(0, 12);
         if ($urandom_range(0, 5) == 0) push_byte(hrf_pkg::CHAR_ZERO);
         push_text($sformatf("%0d", value));
      end
      if ($urandom_range(0, 5) == 0) push_text(" x");
      push_eol();
   endtask

   // Plans one request: mostly well-formed headers and a body, sometimes noise or a cut-off stream.
   task automatic plan_request();
      int first;
      int others;
      int length_at;
      int value;
      int spare_value;
      int trailing;
      bit open_ended;
      bit spare_open;
      bit have_length;
      first = beat_plan.size();
      value = 0;
      trailing = 0;
      open_ended = 1'b0;
      have_length = 1'b0;
      crlf_style = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 24)) push_byte(noise_byte());
         if ($urandom_range(0, 1) == 0) push_eos();
      end else begin
         if ($urandom_range(0, 3) != 0) begin
            push_text("GET /a HTTP/1.1");
            push_eol();
         end
         others = $urandom_range(0, 3);
         length_at = $urandom_range(0, others);
         for (int i = 0; i <= others; i++) begin
            if (i == length_at && $urandom_range(0, 5) != 0) begin
               plan_length_line(value, open_ended);
               have_length = 1'b1;
            end else if (have_length && $urandom_range(0, 1) == 0) begin
               // A later Content-Length line must leave the first value alone.
               plan_length_line(spare_value, spare_open);
            end else begin
               push_text("Host: h");
               push_eol();
            end
         end
         push_eol();
         if (open_ended || $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(0, 6)) push_byte(DATA_W'($urandom));
            push_eos();
         end else begin
            repeat (value) push_byte(DATA_W'($urandom));
            if ($urandom_range(0, 5) == 0) begin
               trailing = $urandom_range(1, 2);
               repeat (trailing) push_byte(DATA_W'($urandom));
            end
         end
      end
      beat_plan[first].new_request = 1'b1;
      items_planned += beat_plan.size() - first - trailing;
   endtask

   // Offers one beat until it is taken; the sender then carries on or rests between bursts.
   task automatic send_beat(input hrf_pkg::req_item_type beat);
      int gap;
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= beat.data_byte;
      req_bus.new_request   <= beat.new_request;
      req_bus.end_of_stream <= beat.end_of_stream;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_plan();
      while (beat_plan.size() != 0) send_beat(beat_plan.pop_front());
   endtask

   // The sender rests until every expected response beat has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LEN_W-1:0] limit);
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [LEN_W-1:0] limit_settings [5];
      limit_settings = '{24'd0, 24'd7, 24'hFFFFFF, 24'd0, 24'd3};
      limit_settings[3] = LEN_W'($urandom);
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.new_request = 1'b0;
      req_bus.end_of_stream = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Bare LF LF completes at once; later bytes of both extremes and end of stream are ignored.
      crlf_style = 1'b0;
      push_beat(hrf_pkg::CHAR_LF, 1'b1, 1'b0);
      push_byte(hrf_pkg::CHAR_LF);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_eos();
      // Stream closed before any terminator.
      push_beat("z", 1'b1, 1'b0);
      push_eos();
      // CR LF CR LF with no Content-Length.
      push_beat(hrf_pkg::CHAR_CR, 1'b1, 1'b0);
      push_byte(hrf_pkg::CHAR_LF);
      push_byte(hrf_pkg::CHAR_CR);
      push_byte(hrf_pkg::CHAR_LF);
      // A new request cuts in on unfinished ones.
      push_beat("a", 1'b1, 1'b0);
      push_beat("C", 1'b1, 1'b0);
      push_beat(hrf_pkg::CHAR_LF, 1'b1, 1'b0);
      push_byte(hrf_pkg::CHAR_LF);
      send_plan();

      // Random requests under each length ceiling.
      for (int p = 0; p < 5; p++) begin
         drain_responses();
         write_limit(limit_settings[p]);
         if (p == 1) long_hold_request = 1'b1;
         items_planned = 0;
         while (items_planned < PHASE_ITEMS) begin
            plan_request();
            send_plan();
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0 && pending_results == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
